FILE: src/swr_pkg.sv
// shared types, constants and helpers for the sliding window receiver
// no dependencies

package swr_pkg;

  localparam int unsigned SeqW       = 16;
  localparam int unsigned MaxSeqBits = 16;
  localparam int unsigned MaxWindow  = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned BitsW      = 5;
  localparam int unsigned WinRegW    = 6;

  localparam logic [CfgIdxW-1:0] CFG_SEQ_BITS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_SEQ = 2'd2;

  localparam logic [BitsW-1:0]   BitsRst = 5'd3;
  localparam logic [WinRegW-1:0] WinRst  = 6'd4;

  typedef enum logic [1:0] {
    DISP_DELIVERED = 2'd0,
    DISP_BUFFERED  = 2'd1,
    DISP_DROPPED   = 2'd2
  } swr_disp_e;

  typedef enum logic {
    ST_IDLE,
    ST_DELIVER
  } swr_state_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } swr_cell_ctrl_t;

  function automatic logic [SeqW-1:0] seq_mask(input logic [BitsW-1:0] bits);
    logic [BitsW-1:0] eb;
    logic [SeqW:0]    m;
    eb = bits;
    if (eb < BitsW'(1)) eb = BitsW'(1);
    if (eb > BitsW'(MaxSeqBits)) eb = BitsW'(MaxSeqBits);
    m = (17'd1 << eb) - 17'd1;
    return m[SeqW-1:0];
  endfunction

endpackage

FILE: src/swr_cell.sv
// one window bitmap cell: holds the mark of one slot, takes its neighbor on a slide
// depends on swr_pkg

module swr_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swr_pkg::swr_cell_ctrl_t ctrl_i,
  input  logic                    set_i,
  input  logic                    in_win_i,
  input  logic                    nb_mark_i,
  output logic                    mark_o
);
  import swr_pkg::*;

  logic mark_q, mark_d;

  always_comb begin
    if (ctrl_i.clear) begin
      mark_d = 1'b0;
    end else if (ctrl_i.shift) begin
      mark_d = nb_mark_i & in_win_i;
    end else if (set_i) begin
      mark_d = 1'b1;
    end else begin
      mark_d = mark_q & in_win_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign mark_o = mark_q;

endmodule

FILE: src/sliding_window_receiver.sv
// sliding window receiver top level: config registers, sequencer, output register,
// and the chain of window cells. depends on swr_pkg and swr_cell
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   in        | in_valid_i, in_ready_o, seq_num_i         | sink
//   out       | out_valid_o, out_ready_i, disposition_o,  | source
//             | seq_out_o, next_expected_o, last_o        |
//   cfg       | cfg_we_i, cfg_idx_i, cfg_data_i           | sink
//
// a dropped or buffered packet yields one beat straight from idle.
// an in-order packet moves the sequencer to the deliver state, which yields one beat per
// delivered packet (at most the window size), each with a single shift of the cell chain.
// reset empties the window, expected number 0, width 3, window 4.
// a stalled output holds the sequencer; input is taken only in idle.

module sliding_window_receiver #(
  parameter int unsigned MaxWindow = swr_pkg::MaxWindow
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [swr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swr_pkg::SeqW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [swr_pkg::SeqW-1:0]    seq_num_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  disposition_o,
  output logic [swr_pkg::SeqW-1:0]    seq_out_o,
  output logic [swr_pkg::SeqW-1:0]    next_expected_o,
  output logic                        last_o
);
  import swr_pkg::*;

  localparam int unsigned WinW = $clog2(MaxWindow + 1);
  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;

  logic [BitsW-1:0]   bits_q;
  logic [WinRegW-1:0] win_q;
  logic [SeqW-1:0]    exp_q, exp_d;
  swr_state_e         state_q, state_d;

  logic               out_valid_q;
  swr_disp_e          disp_q, disp_d;
  logic [SeqW-1:0]    seq_out_q, seq_out_d;
  logic [SeqW-1:0]    next_q, next_d;
  logic               last_q, last_d;

  logic [SeqW-1:0]    mask, seq_m, ahead, exp_inc, lim, win_ext;
  logic [WinW-1:0]    eff_win;
  logic               in_window, marked, in_fire, slot_free, load_out, set_en;
  logic [IdxW-1:0]    set_idx;
  swr_cell_ctrl_t     ctrl;
  logic [MaxWindow-1:0] marks;
  logic [MaxWindow:0]   marks_ext;

  // effective width and window
  assign mask = seq_mask(bits_q);
  always_comb begin
    lim = (SeqW'(MaxWindow) < mask) ? SeqW'(MaxWindow) : mask;
    win_ext = SeqW'(win_q);
    if (win_ext < SeqW'(1)) win_ext = SeqW'(1);
    if (win_ext > lim) win_ext = lim;
  end
  assign eff_win = win_ext[WinW-1:0];

  assign seq_m     = seq_num_i & mask;
  assign ahead     = (seq_m - exp_q) & mask;
  assign in_window = ahead < SeqW'(eff_win);
  assign set_idx   = ahead[IdxW-1:0];
  assign marked    = in_window && marks[set_idx];
  assign exp_inc   = (exp_q + SeqW'(1)) & mask;
  assign marks_ext = {1'b0, marks};

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_window && !marked && ahead == '0) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (slot_free && !marks_ext[1]) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    set_en     = 1'b0;
    ctrl       = '0;
    exp_d      = exp_q;
    disp_d     = disp_q;
    seq_out_d  = seq_out_q;
    next_d     = next_q;
    last_d     = last_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_fire) begin
          if (!in_window || marked) begin
            load_out  = 1'b1;
            disp_d    = DISP_DROPPED;
            seq_out_d = seq_m;
            next_d    = exp_q;
            last_d    = 1'b1;
          end else begin
            set_en = 1'b1;
            if (ahead != '0) begin
              load_out  = 1'b1;
              disp_d    = DISP_BUFFERED;
              seq_out_d = seq_m;
              next_d    = exp_q;
              last_d    = 1'b1;
            end
          end
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          load_out   = 1'b1;
          ctrl.shift = 1'b1;
          disp_d     = DISP_DELIVERED;
          seq_out_d  = exp_q;
          next_d     = exp_inc;
          last_d     = !marks_ext[1];
          exp_d      = exp_inc;
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEQ_BITS:    exp_d = exp_q & seq_mask(cfg_data_i[BitsW-1:0]);
        CFG_INITIAL_SEQ: begin
          exp_d      = cfg_data_i & mask;
          ctrl.clear = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= BitsRst;
      win_q       <= WinRst;
      exp_q       <= '0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SEQ_BITS) bits_q <= cfg_data_i[BitsW-1:0];
      if (cfg_we_i && cfg_idx_i == CFG_WINDOW_SIZE) win_q <= cfg_data_i[WinRegW-1:0];
      exp_q   <= exp_d;
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      disp_q    <= disp_d;
      seq_out_q <= seq_out_d;
      next_q    <= next_d;
      last_q    <= last_d;
    end
  end

  // window cells, slot k holds the packet k ahead of the expected number
  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    swr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .set_i     (set_en && set_idx == IdxW'(k)),
      .in_win_i  (WinW'(k) < eff_win),
      .nb_mark_i (marks_ext[k+1]),
      .mark_o    (marks[k])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign disposition_o   = disp_q;
  assign seq_out_o       = seq_out_q;
  assign next_expected_o = next_q;
  assign last_o          = last_q;

endmodule

FILE: test/swr_checker.sv
// checker for the sliding window receiver: tracks register writes and input beats,
// predicts every output beat and compares the accepted ones in order
// depends on swr_pkg

module swr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [swr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swr_pkg::SeqW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [swr_pkg::SeqW-1:0]    seq_num_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [1:0]                  disposition_i,
  input  logic [swr_pkg::SeqW-1:0]    seq_out_i,
  input  logic [swr_pkg::SeqW-1:0]    next_expected_i,
  input  logic                        last_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output logic [swr_pkg::SeqW-1:0]    exp_seq_o,
  output logic [swr_pkg::SeqW-1:0]    seq_mask_o,
  output int unsigned                 win_o,
  output int unsigned                 delivered_o,
  output int unsigned                 buffered_o,
  output int unsigned                 dropped_o,
  output int unsigned                 longest_run_o
);
  import swr_pkg::*;

  typedef struct packed {
    swr_disp_e       disp;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] nxt;
    logic            last;
  } rx_beat_t;

  rx_beat_t             due_beats[$];
  rx_beat_t             want;
  logic [BitsW-1:0]     width_reg;
  logic [WinRegW-1:0]   span_reg;
  logic [SeqW-1:0]      exp_seq;
  logic [MaxWindow-1:0] arrived;
  int unsigned          fails = 0;

  assign fail_count_o = fails;

  function automatic logic [SeqW-1:0] width_mask(input logic [BitsW-1:0] w);
    int unsigned n;
    n = w;
    if (n < 1) n = 1;
    if (n > MaxSeqBits) n = MaxSeqBits;
    return SeqW'((32'd1 << n) - 32'd1);
  endfunction

  function automatic int unsigned span_eff(input logic [BitsW-1:0] w,
                                           input logic [WinRegW-1:0] s);
    int unsigned lim;
    int unsigned v;
    lim = width_mask(w);
    if (lim > MaxWindow) lim = MaxWindow;
    v = s;
    if (v < 1) v = 1;
    if (v > lim) v = lim;
    return v;
  endfunction

  function automatic logic [MaxWindow-1:0] span_bits(input int unsigned n);
    return MaxWindow'((64'd1 << n) - 64'd1);
  endfunction

  task automatic tidy_state();
    exp_seq = exp_seq & width_mask(width_reg);
    arrived = arrived & span_bits(span_eff(width_reg, span_reg));
  endtask

  task automatic predict_packet(input logic [SeqW-1:0] raw);
    logic [SeqW-1:0] m;
    logic [SeqW-1:0] s;
    logic [SeqW-1:0] gap;
    int unsigned     w;
    int unsigned     n;
    rx_beat_t        b;
    m = width_mask(width_reg);
    w = span_eff(width_reg, span_reg);
    s = raw & m;
    tidy_state();
    gap = (s - exp_seq) & m;
    b.seq = s;
    b.nxt = exp_seq;
    b.last = 1'b1;
    if (gap >= w || arrived[gap]) begin
      b.disp = DISP_DROPPED;
      due_beats.push_back(b);
    end else if (gap != 0) begin
      arrived[gap] = 1'b1;
      b.disp = DISP_BUFFERED;
      due_beats.push_back(b);
    end else begin
      // in-order arrival: release it and every marked packet right behind it
      arrived[0] = 1'b1;
      n = 0;
      while (arrived[0] && n < MaxWindow) begin
        b.disp = DISP_DELIVERED;
        b.seq = exp_seq;
        exp_seq = (exp_seq + 1'b1) & m;
        arrived = arrived >> 1;
        n++;
        b.nxt = exp_seq;
        b.last = !arrived[0] || n >= MaxWindow;
        due_beats.push_back(b);
      end
      if (n > longest_run_o) longest_run_o = n;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = BitsRst;
      span_reg = WinRst;
      exp_seq = '0;
      arrived = '0;
      due_beats.delete();
      pending_o <= 0;
      exp_seq_o <= '0;
      seq_mask_o <= width_mask(BitsRst);
      win_o <= span_eff(BitsRst, WinRst);
      delivered_o = 0;
      buffered_o = 0;
      dropped_o = 0;
      longest_run_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_beats.size() == 0) begin
          $error("no beat expected, got seq_out %0h", seq_out_i);
          fails++;
        end else begin
          want = due_beats.pop_front();
          case (want.disp)
            DISP_DELIVERED: delivered_o++;
            DISP_BUFFERED:  buffered_o++;
            default:        dropped_o++;
          endcase
          if (disposition_i !== want.disp) begin
            $error("disposition: expected %0d, got %0d", want.disp, disposition_i);
            fails++;
          end
          if (seq_out_i !== want.seq) begin
            $error("seq_out: expected %0h, got %0h", want.seq, seq_out_i);
            fails++;
          end
          if (next_expected_i !== want.nxt) begin
            $error("next_expected: expected %0h, got %0h", want.nxt, next_expected_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_packet(seq_num_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEQ_BITS: begin
            width_reg = cfg_data_i[BitsW-1:0];
            tidy_state();
          end
          CFG_WINDOW_SIZE: begin
            span_reg = cfg_data_i[WinRegW-1:0];
            tidy_state();
          end
          CFG_INITIAL_SEQ: begin
            exp_seq = cfg_data_i & width_mask(width_reg);
            arrived = '0;
          end
          default: ;
        endcase
      end
      pending_o <= due_beats.size();
      exp_seq_o <= exp_seq;
      seq_mask_o <= width_mask(width_reg);
      win_o <= span_eff(width_reg, span_reg);
    end
  end

endmodule

FILE: test/tb.sv
// testbench top for the sliding window receiver: drives register writes, packet
// numbers and output back-pressure, and reports the verdict
// depends on swr_pkg, sliding_window_receiver and swr_checker

module tb;
  import swr_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned LimitCycles   = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_SEQ_BITS;
  logic [SeqW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic [SeqW-1:0]    seq_num_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         disposition_o;
  logic [SeqW-1:0]    seq_out_o;
  logic [SeqW-1:0]    next_expected_o;
  logic               last_o;

  int unsigned        fail_count;
  int unsigned        pending;
  logic [SeqW-1:0]    exp_seq_now;
  logic [SeqW-1:0]    mask_now;
  int unsigned        win_now;
  int unsigned        n_delivered;
  int unsigned        n_buffered;
  int unsigned        n_dropped;
  int unsigned        longest_run;

  logic               steady = 1'b0;
  logic               hold_off_req = 1'b0;
  int unsigned        sent = 0;
  int unsigned        cfg_writes = 0;

  sliding_window_receiver dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .seq_num_i,
    .out_valid_o,
    .out_ready_i,
    .disposition_o,
    .seq_out_o,
    .next_expected_o,
    .last_o
  );

  swr_checker chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .seq_num_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .disposition_i   (disposition_o),
    .seq_out_i       (seq_out_o),
    .next_expected_i (next_expected_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .exp_seq_o       (exp_seq_now),
    .seq_mask_o      (mask_now),
    .win_o           (win_now),
    .delivered_o     (n_delivered),
    .buffered_o      (n_buffered),
    .dropped_o       (n_dropped),
    .longest_run_o   (longest_run)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  initial begin
    #(2 * HalfPeriod * LimitCycles);
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random bits above the sequence width, which the block must ignore
  function automatic logic [SeqW-1:0] dress(input logic [SeqW-1:0] v,
                                            input logic [SeqW-1:0] m);
    return (SeqW'($urandom) & ~m) | (v & m);
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : sink
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req <= 1'b0;
        out_ready_i <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        n = pick_gap() + 1;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_seq(input logic [SeqW-1:0] v);
    int unsigned g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    seq_num_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // wait until every predicted beat has come out and the block takes input again
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || !in_ready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SeqW-1:0] val,
                           input bit more);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (!more) cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // shuffled run of packets from the window start, with some noise mixed in on a run that is not full;
  // a full run fills the whole window and sends the expected number last
  task automatic run_burst(input bit full);
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] m;
    logic [SeqW-1:0] v;
    int unsigned     w;
    int unsigned     k;
    int unsigned     tmp;
    int              j;
    int              t;
    int unsigned     order[$];
    settle();
    base = exp_seq_now;
    m = mask_now;
    w = win_now;
    k = full ? w : $urandom_range(1, w);
    steady <= full || $urandom_range(0, 4) == 0;
    if (full) hold_off_req <= 1'b1;
    order.delete();
    for (j = 0; j < k; j++) order.push_back(j);
    for (j = k - 1; j > 0; j--) begin
      t = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[t];
      order[t] = tmp;
    end
    if (full || $urandom_range(0, 3) == 0) begin
      t = 0;
      for (j = 0; j < k; j++) if (order[j] == 0) t = j;
      order[t] = order[k-1];
      order[k-1] = 0;
    end
    for (j = 0; j < k; j++) begin
      if (!full && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0:       v = base + SeqW'(order[$urandom_range(0, j)]);
          1:       v = base + SeqW'($urandom_range(w, m));
          default: v = SeqW'($urandom);
        endcase
        send_seq(dress(v, m));
      end
      send_seq(dress(base + SeqW'(order[j]), m));
    end
  endtask

  task automatic run_phase(input int unsigned goal);
    while (sent < goal) run_burst(1'b0);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: width 3, window 4
    send_seq(16'h0000);
    send_seq(16'h0003);
    send_seq(16'h0002);
    send_seq(16'h0002);
    send_seq(16'h0001);
    send_seq(16'hFFFF);
    send_seq(16'h0005);
    send_seq(16'h0007);
    send_seq(16'h0000);
    send_seq(16'h0004);
    send_seq(16'h0006);
    run_phase(25);

    // zero width and zero window act as one; upper data bits ignored
    settle();
    write_reg(CFG_SEQ_BITS, 16'hFFE0, 1'b1);
    write_reg(CFG_WINDOW_SIZE, 16'hFFC0, 1'b1);
    write_reg(CFG_INITIAL_SEQ, 16'hFFFF, 1'b0);
    run_phase(40);

    // full width and widest window, starting just below the wrap
    settle();
    write_reg(CFG_SEQ_BITS, 16'd16, 1'b1);
    write_reg(CFG_WINDOW_SIZE, 16'd32, 1'b1);
    write_reg(CFG_INITIAL_SEQ, 16'hFFF0, 1'b0);
    run_burst(1'b1);
    run_burst(1'b0);
    run_phase(85);

    // out-of-range width and window saturate
    settle();
    write_reg(CFG_SEQ_BITS, 16'd31, 1'b1);
    write_reg(CFG_WINDOW_SIZE, 16'd63, 1'b1);
    write_reg(CFG_INITIAL_SEQ, SeqW'($urandom), 1'b0);
    run_phase(105);

    // window clamped to the number space
    settle();
    write_reg(CFG_SEQ_BITS, 16'd2, 1'b1);
    write_reg(CFG_WINDOW_SIZE, 16'd5, 1'b1);
    write_reg(CFG_INITIAL_SEQ, 16'hABCD, 1'b0);
    run_phase(125);

    // shrink window and width while packets are buffered
    settle();
    write_reg(CFG_SEQ_BITS, 16'd5, 1'b1);
    write_reg(CFG_WINDOW_SIZE, 16'd20, 1'b1);
    write_reg(CFG_INITIAL_SEQ, 16'h001E, 1'b0);
    send_seq(16'h0021);
    send_seq(16'h0028);
    send_seq(16'h002D);
    settle();
    write_reg(CFG_WINDOW_SIZE, 16'd6, 1'b1);
    write_reg(CFG_SEQ_BITS, 16'd4, 1'b0);
    send_seq(16'h0008);
    send_seq(16'h0001);
    send_seq(16'h000E);
    run_phase(155);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d packets over %0d register writes, longest delivery run %0d beats",
             sent, cfg_writes, longest_run);
    $display("beats seen: %0d delivered, %0d buffered, %0d dropped",
             n_delivered, n_buffered, n_dropped);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
